// ----- rtl/core/dci_pkg.sv -----
`default_nettype none

package dci_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned NARROW_W  = 32;
    localparam int unsigned CODE_W    = 2;
    localparam int unsigned NBYTES_W  = 4;
    localparam int unsigned SLOTS     = 4;
    localparam int unsigned SLOT_W    = $clog2(SLOTS);
    localparam int unsigned CBYTE_W   = CODE_W * SLOTS;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned OUT_W     = 80;

    typedef enum logic [CODE_W-1:0] {
        CODE_COMMON = 2'd0,
        CODE_SMALL  = 2'd1,
        CODE_MEDIUM = 2'd2,
        CODE_LARGE  = 2'd3
    } t_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMMON_DELTA = 1'd0,
        REG_WIDE_MODE    = 1'd1
    } t_reg_idx;

    typedef struct packed {
        t_code              code;
        logic [WORD_W-1:0]  payload;
        logic [NBYTES_W-1:0] payload_bytes;
    } t_cls;

    typedef struct packed {
        logic [CBYTE_W-1:0] code_byte;
        logic               code_byte_valid;
    } t_pack;

endpackage

`default_nettype wire

// ----- rtl/core/dci_classify.sv -----
`default_nettype none

module dci_classify
    import dci_pkg::*;
(
    input  wire logic [WORD_W-1:0] i_cur,
    input  wire logic [WORD_W-1:0] i_prev,
    input  wire logic              i_wide,
    input  wire logic [WORD_W-1:0] i_common,
    output t_cls                   o_cls
);

    logic [WORD_W-1:0] diff;
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] common;
    logic              fits_small;
    logic              fits_medium;

    always_comb begin
        diff = i_cur - i_prev;
        if (i_wide) begin
            delta  = diff;
            common = i_common;
            // small: signed 16, medium: signed 32
            fits_small  = (&delta[WORD_W-1:15]) || !(|delta[WORD_W-1:15]);
            fits_medium = (&delta[WORD_W-1:31]) || !(|delta[WORD_W-1:31]);
        end else begin
            delta  = {{(WORD_W-NARROW_W){diff[NARROW_W-1]}}, diff[NARROW_W-1:0]};
            common = {{(WORD_W-NARROW_W){i_common[NARROW_W-1]}}, i_common[NARROW_W-1:0]};
            // small: signed 8, medium: signed 16
            fits_small  = (&delta[WORD_W-1:7]) || !(|delta[WORD_W-1:7]);
            fits_medium = (&delta[WORD_W-1:15]) || !(|delta[WORD_W-1:15]);
        end

        o_cls.payload = delta;
        priority if (delta == common) begin
            o_cls.code          = CODE_COMMON;
            o_cls.payload       = '0;
            o_cls.payload_bytes = 4'd0;
        end else if (fits_small) begin
            o_cls.code          = CODE_SMALL;
            o_cls.payload_bytes = i_wide ? 4'd2 : 4'd1;
        end else if (fits_medium) begin
            o_cls.code          = CODE_MEDIUM;
            o_cls.payload_bytes = i_wide ? 4'd4 : 4'd2;
        end else begin
            o_cls.code          = CODE_LARGE;
            o_cls.payload_bytes = i_wide ? 4'd8 : 4'd4;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dci_pack.sv -----
`default_nettype none

module dci_pack
    import dci_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_code i_code,
    input  wire logic  i_last,
    output t_pack      o_pack
);

    logic [CBYTE_W-1:0] r_acc;
    logic [SLOT_W-1:0]  r_slot;
    logic [CBYTE_W-1:0] n_acc;
    logic [SLOT_W-1:0]  n_slot;
    logic               emit;

    always_comb begin
        n_acc  = r_acc | (CBYTE_W'(i_code) << (CODE_W * r_slot));
        n_slot = r_slot + 1'b1;
        emit   = i_last || (n_slot == '0);
        o_pack.code_byte       = emit ? n_acc : '0;
        o_pack.code_byte_valid = emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_slot <= '0;
        end else if (i_step) begin
            r_acc  <= emit ? '0 : n_acc;
            r_slot <= emit ? '0 : n_slot;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/delta_class_integer_encoder.sv -----
// Delta-class integer encoder.
// Slave stream carries one integer per item (tdata = value, tlast = final
// integer of the array). Master stream carries one result per item: the
// 2-bit size class of the delta from the previous integer, the delta
// sign-extended to 64 bits (zero for the common class), the payload
// byte count, and a packed code byte that is flagged valid every fourth
// item or at the last item of the array. Configuration (common delta, wide
// mode) is written through a plain write port, only while no item is in
// flight; the user is bound to this, the block does not enforce it.
// Data path: input register, subtract/compare/pack logic, result register.
// Throughput: one item per cycle while the receiver is ready; each stage
// advances when the stage after it is empty or being drained, so a
// stalled receiver backs up both stages and then drops s_axis_tready.
// Reset (synchronous, active low) empties both stages and clears the
// previous value, code accumulator, slot count and configuration.
// After the last item the previous value and slot count return to zero.
`default_nettype none

module delta_class_integer_encoder
    import dci_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [WORD_W-1:0]    s_axis_tdata,   // [63:0] value
    input  wire logic                 s_axis_tlast,   // is_last
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [1:0] code, [65:2] payload, [69:66] payload_bytes, [77:70] code_byte,
    // [78] code_byte_valid, [79] zero
    output logic [OUT_W-1:0]          m_axis_tdata,
    output logic                      m_axis_tlast,   // end_of_array
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    logic [WORD_W-1:0] r_common;
    logic              r_wide;

    logic [WORD_W-1:0] r_prev;
    logic              r_a_valid;
    logic [WORD_W-1:0] r_a_cur;
    logic [WORD_W-1:0] r_a_prev;
    logic              r_a_last;

    logic              r_b_valid;
    t_cls              r_b_cls;
    t_pack             r_b_pack;
    logic              r_b_last;

    logic              b_ready;
    logic              a_ready;
    logic              in_acc;
    logic              step;
    logic [WORD_W-1:0] cur;
    t_cls              cls;
    t_pack             pack;

    assign b_ready = !r_b_valid || m_axis_tready;
    assign a_ready = !r_a_valid || b_ready;
    assign step    = r_a_valid && b_ready;
    assign in_acc  = s_axis_tvalid && a_ready;
    assign cur     = r_wide ? s_axis_tdata
                            : {{(WORD_W-NARROW_W){1'b0}}, s_axis_tdata[NARROW_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_common <= '0;
            r_wide   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_COMMON_DELTA: r_common <= i_cfg_data;
                REG_WIDE_MODE:    r_wide   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_prev    <= s_axis_tlast ? '0 : cur;
                r_a_valid <= 1'b1;
            end else if (step) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_cur  <= cur;
            r_a_prev <= r_prev;
            r_a_last <= s_axis_tlast;
        end
    end

    dci_classify u_classify (
        .i_cur    (r_a_cur),
        .i_prev   (r_a_prev),
        .i_wide   (r_wide),
        .i_common (r_common),
        .o_cls    (cls)
    );

    dci_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_code  (cls.code),
        .i_last  (r_a_last),
        .o_pack  (pack)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (step) begin
            r_b_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_b_cls  <= cls;
            r_b_pack <= pack;
            r_b_last <= r_a_last;
        end
    end

    assign s_axis_tready = a_ready;
    assign m_axis_tvalid = r_b_valid;
    assign m_axis_tlast  = r_b_last;
    assign m_axis_tdata  = {1'b0, r_b_pack.code_byte_valid, r_b_pack.code_byte,
                            r_b_cls.payload_bytes, r_b_cls.payload, r_b_cls.code};

endmodule

`default_nettype wire

// ----- tb/delta_class_integer_encoder_test.sv -----
`timescale 1ns / 1ps

typedef struct packed {
    dci_pkg::t_code code;
    logic [63:0]    payload;
    logic [3:0]     payload_bytes;
    logic [7:0]     code_byte;
    logic           code_byte_valid;
    logic           end_of_array;
} delta_result_t;

// sign-extend the low bits of v to 64 bits (1..64 bits)
function automatic logic [63:0] sign_fill(input logic [63:0] v, input int unsigned bits);
    logic [63:0] keep;
    logic [63:0] sbit;
    keep = (64'd1 << bits) - 64'd1;
    sbit = 64'd1 << (bits - 1);
    return ((v & keep) ^ sbit) - sbit;
endfunction

class code_stream_tracker;
    logic [63:0]   common_delta;
    logic          wide;
    logic [63:0]   prev_value;
    logic [7:0]    code_acc;
    logic [1:0]    slot;
    delta_result_t pending[$];
    int            mismatches;
    int            code_seen[4];
    int            bytes_out;
    int            arrays_out;

    function new();
        common_delta = '0;
        wide         = 1'b0;
        prev_value   = '0;
        code_acc     = '0;
        slot         = '0;
        mismatches   = 0;
        bytes_out    = 0;
        arrays_out   = 0;
        foreach (code_seen[i]) code_seen[i] = 0;
    endfunction

    function void set_reg(input dci_pkg::t_reg_idx idx, input logic [63:0] data);
        case (idx)
            dci_pkg::REG_COMMON_DELTA: common_delta = data;
            dci_pkg::REG_WIDE_MODE:    wide = data[0];
            default: ;
        endcase
    endfunction

    // classify one accepted integer and queue the result it must produce
    function void accept_integer(input logic [63:0] value, input logic is_end);
        delta_result_t r;
        logic [63:0]   cur;
        logic [63:0]   prv;
        logic [63:0]   delta;
        logic [63:0]   common;
        int unsigned   small_w;
        int unsigned   mid_w;
        int unsigned   word_w;
        word_w  = wide ? 64 : 32;
        small_w = wide ? 16 : 8;
        mid_w   = wide ? 32 : 16;
        cur     = wide ? value : {32'd0, value[31:0]};
        prv     = wide ? prev_value : {32'd0, prev_value[31:0]};
        delta   = sign_fill(cur - prv, word_w);
        common  = sign_fill(common_delta, word_w);
        r.payload = delta;
        if (delta == common) begin
            r.code          = dci_pkg::CODE_COMMON;
            r.payload       = '0;
            r.payload_bytes = 4'd0;
        end else if (sign_fill(delta, small_w) == delta) begin
            r.code          = dci_pkg::CODE_SMALL;
            r.payload_bytes = 4'(small_w / 8);
        end else if (sign_fill(delta, mid_w) == delta) begin
            r.code          = dci_pkg::CODE_MEDIUM;
            r.payload_bytes = 4'(mid_w / 8);
        end else begin
            r.code          = dci_pkg::CODE_LARGE;
            r.payload_bytes = 4'(word_w / 8);
        end
        code_acc = code_acc | ({6'd0, r.code} << (2 * slot));
        slot     = slot + 2'd1;
        r.code_byte_valid = is_end || (slot == 2'd0);
        r.code_byte       = r.code_byte_valid ? code_acc : 8'd0;
        r.end_of_array    = is_end;
        if (r.code_byte_valid) begin
            code_acc = '0;
            slot     = '0;
        end
        prev_value = is_end ? 64'd0 : cur;
        pending.push_back(r);
    endfunction

    function void check_result(input logic [79:0] data, input logic eoa);
        delta_result_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: tdata=%h tlast=%b", data, eoa);
            return;
        end
        e = pending.pop_front();
        if (data[1:0] !== e.code || data[65:2] !== e.payload ||
            data[69:66] !== e.payload_bytes || data[77:70] !== e.code_byte ||
            data[78] !== e.code_byte_valid || eoa !== e.end_of_array) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: exp code=%0d payload=%h bytes=%0d cbyte=%h cbv=%b eoa=%b",
                         e.code, e.payload, e.payload_bytes, e.code_byte,
                         e.code_byte_valid, e.end_of_array);
                $display("          got code=%0d payload=%h bytes=%0d cbyte=%h cbv=%b eoa=%b",
                         data[1:0], data[65:2], data[69:66], data[77:70], data[78], eoa);
            end
        end
        code_seen[int'(e.code)]++;
        if (e.code_byte_valid) bytes_out++;
        if (e.end_of_array) arrays_out++;
    endfunction
endclass

module delta_class_integer_encoder_test;
    import dci_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 133;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [WORD_W-1:0]    s_axis_tdata = '0;   // [63:0] value
    logic                 s_axis_tlast = 1'b0; // is_last
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [1:0] code, [65:2] payload, [69:66] payload_bytes, [77:70] code_byte,
    // [78] code_byte_valid, [79] zero
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;        // end_of_array
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    code_stream_tracker tracker = new();
    logic [63:0] drv_prev = '0;
    logic        tx_steady = 1'b0;
    logic        rx_steady = 1'b0;
    int          items_sent = 0;
    int          idle_cycles = 0;

    delta_class_integer_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // delta drawn around the class boundaries of the current mode
    function automatic logic [63:0] pick_delta();
        int unsigned small_w;
        int unsigned mid_w;
        int unsigned word_w;
        logic [63:0] r;
        logic [63:0] d;
        small_w = tracker.wide ? 16 : 8;
        mid_w   = tracker.wide ? 32 : 16;
        word_w  = tracker.wide ? 64 : 32;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0, 1:    d = tracker.common_delta;
            2, 3:    d = sign_fill(r, small_w);
            4:       d = r[0] ? (64'd1 << (small_w - 1)) - 64'd1 : -(64'd1 << (small_w - 1));
            5:       d = r[0] ? (64'd1 << (small_w - 1)) : -(64'd1 << (small_w - 1)) - 64'd1;
            6, 7:    d = sign_fill(r, mid_w);
            8:       d = r[0] ? (64'd1 << (mid_w - 1)) - 64'd1 : -(64'd1 << (mid_w - 1));
            9:       d = r[0] ? (64'd1 << (mid_w - 1)) : -(64'd1 << (mid_w - 1)) - 64'd1;
            10:      d = sign_fill(r, word_w);
            default: d = r[0] ? (64'd1 << (word_w - 1)) - 64'd1 : -(64'd1 << (word_w - 1));
        endcase
        return d;
    endfunction

    task automatic send_integer(input logic [63:0] value, input logic is_end);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= is_end;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.accept_integer(value, is_end);
        items_sent++;
        drv_prev = is_end ? 64'd0 : (tracker.wide ? value : {32'd0, value[31:0]});
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_delta(input logic [63:0] d, input logic is_end);
        send_integer(drv_prev + d, is_end);
    endtask

    task automatic send_array(input int len, input logic close);
        logic [63:0] v;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                v = {$urandom, $urandom};
            end else begin
                v = drv_prev + pick_delta();
                if (!tracker.wide) v[63:32] = $urandom;
            end
            send_integer(v, close && (i == len - 1));
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic wide, input logic [63:0] common);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_COMMON_DELTA;
        i_cfg_data <= common;
        @(posedge i_clk);
        tracker.set_reg(REG_COMMON_DELTA, common);
        i_cfg_idx  <= REG_WIDE_MODE;
        i_cfg_data <= {63'd0, wide};
        @(posedge i_clk);
        tracker.set_reg(REG_WIDE_MODE, {63'd0, wide});
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    // receiver backpressure
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = rx_steady ? 0 : idle_len();
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [63:0] narrow_d[11];
        logic        narrow_end[11];
        logic [63:0] wide_d[12];
        logic        wide_set[PHASES];
        logic [63:0] common_set[PHASES];
        int          done_items;
        int          len;
        int          errors;

        narrow_d = '{64'd0, 64'd127, -64'd128, 64'd128, -64'd129, 64'd32767, -64'd32768,
                     64'd32768, -64'd32769, 64'h7FFF_FFFF, 64'hFFFF_FFFF_8000_0000};
        narrow_end = '{0, 0, 0, 0, 1, 0, 1, 0, 0, 1, 0};
        wide_d = '{64'h8000_0000_0000_0000, 64'd0, 64'd32767, -64'd32768, 64'd32768,
                   -64'd32769, 64'h7FFF_FFFF, -64'h8000_0000, 64'h8000_0000,
                   -64'h8000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1};
        wide_set = '{0, 0, 1, 1, 0, 1, 0, 1, 1, 0};
        common_set = '{64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                       64'h7FFF_FFFF_FFFF_FFFF, 64'hDEAD_0000_7FFF_FFFF, 64'd0,
                       64'h0000_0001_8000_0000, {$urandom, $urandom},
                       64'hFFFF_FFFF_FFFF_FF80, 64'h0000_0000_0000_0100};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: narrow, common delta 0; class edges and short final groups
        for (int i = 0; i < 11; i++) send_delta(narrow_d[i], narrow_end[i]);
        wait_drained();
        // switch to wide in the middle of an array
        write_mode(1'b1, 64'h8000_0000_0000_0000);
        for (int i = 0; i < 12; i++) send_delta(wide_d[i], i == 11);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_mode(wide_set[p], common_set[p]);
            tx_steady  = (p % 3 == 1);
            rx_steady  = (p % 4 == 2);
            done_items = 0;
            while (done_items < PHASE_LEN) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                if (done_items + len > PHASE_LEN) begin
                    len = PHASE_LEN - done_items;
                    send_array(len, 1'($urandom_range(0, 1)));
                end else begin
                    send_array(len, $urandom_range(0, 19) != 0);
                end
                done_items += len;
                if (p == 3 && done_items >= PHASE_LEN / 2 && done_items - len < PHASE_LEN / 2)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        errors = tracker.mismatches + tracker.pending.size();
        $display("%0d integers in %0d arrays, %0d code bytes; classes common/small/medium/large",
                 items_sent, tracker.arrays_out, tracker.bytes_out);
        $display("  = %0d/%0d/%0d/%0d over %0d mode settings, %0d mismatches",
                 tracker.code_seen[0], tracker.code_seen[1], tracker.code_seen[2],
                 tracker.code_seen[3], PHASES + 2, errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/dci_pkg.sv
rtl/core/dci_classify.sv
rtl/core/dci_pack.sv
rtl/core/delta_class_integer_encoder.sv
tb/delta_class_integer_encoder_test.sv
